FILE: rtl/jfm_pkg.sv
`default_nettype none

package jfm_pkg;

    // command codes
    localparam logic [2:0] CMD_ENCODER  = 3'd0;
    localparam logic [2:0] CMD_RANGE    = 3'd1;
    localparam logic [2:0] CMD_MOVE     = 3'd2;
    localparam logic [2:0] CMD_MOVE_RST = 3'd3;
    localparam logic [2:0] CMD_LINK     = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    // fault codes
    localparam logic [2:0] CODE_NONE      = 3'd0;
    localparam logic [2:0] CODE_ENCODER   = 3'd1;
    localparam logic [2:0] CODE_RANGE     = 3'd2;
    localparam logic [2:0] CODE_COLLISION = 3'd3;
    localparam logic [2:0] CODE_MOVE_FAIL = 3'd4;
    localparam logic [2:0] CODE_LINK      = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_STEP   = 3'd0;
    localparam logic [2:0] REG_POS_LOW    = 3'd1;
    localparam logic [2:0] REG_POS_HIGH   = 3'd2;
    localparam logic [2:0] REG_COLL_LIMIT = 3'd3;
    localparam logic [2:0] REG_STALL_LIM  = 3'd4;
    localparam logic [2:0] REG_LINK_TMO   = 3'd5;

    localparam logic [30:0] MAG_MAX   = '1;
    localparam logic [15:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [30:0] max_encoder_step;
        logic [31:0] position_low;
        logic [31:0] position_high;
        logic [15:0] collision_limit;
        logic [15:0] stall_limit;
        logic [31:0] link_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] sample_value;
        logic [31:0] last_msg_ms;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic        fault_flag;
        logic [2:0]  fault_kind;
        logic [30:0] previous_error_mag;
        logic [15:0] nonshrink_count;
    } t_state;

    typedef struct packed {
        logic       tripped;
        logic       fault_latched;
        logic [2:0] fault_code;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/jfm_cfg.sv
`default_nettype none

module jfm_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output jfm_pkg::t_cfg     o_cfg
);
    import jfm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register decode, writes beyond the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_STEP:   n_cfg.max_encoder_step = i_cfg_data[30:0];
                REG_POS_LOW:    n_cfg.position_low     = i_cfg_data;
                REG_POS_HIGH:   n_cfg.position_high    = i_cfg_data;
                REG_COLL_LIMIT: n_cfg.collision_limit  = i_cfg_data[15:0];
                REG_STALL_LIM:  n_cfg.stall_limit      = i_cfg_data[15:0];
                REG_LINK_TMO:   n_cfg.link_timeout_ms  = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_encoder_step <= MAG_MAX;
            r_cfg.position_low     <= 32'h8000_0000;
            r_cfg.position_high    <= 32'h7FFF_FFFF;
            r_cfg.collision_limit  <= COUNT_MAX;
            r_cfg.stall_limit      <= COUNT_MAX;
            r_cfg.link_timeout_ms  <= 32'hFFFF_FFFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/jfm_check.sv
`default_nettype none

module jfm_check (
    input  wire jfm_pkg::t_item    i_item,
    input  wire jfm_pkg::t_cfg     i_cfg,
    input  wire jfm_pkg::t_state   i_state,
    output jfm_pkg::t_state   o_state,
    output jfm_pkg::t_result  o_result
);
    import jfm_pkg::*;

    logic [31:0] w_neg;
    logic [30:0] w_mag;
    logic [15:0] w_count;
    logic [31:0] w_elapsed;
    logic        w_enc_bad;
    logic        w_range_bad;
    logic        w_link_bad;
    logic        w_tripped;
    t_state      w_next;

    // saturating magnitude of the sample
    assign w_neg = 32'd0 - i_item.sample_value;
    always_comb begin
        if (!i_item.sample_value[31]) begin
            w_mag = i_item.sample_value[30:0];
        end else if (w_neg[31]) begin
            w_mag = MAG_MAX;
        end else begin
            w_mag = w_neg[30:0];
        end
    end

    // non-shrinking counter, saturating
    always_comb begin
        if (w_mag >= i_state.previous_error_mag) begin
            w_count = (i_state.nonshrink_count == COUNT_MAX) ? COUNT_MAX
                                                             : i_state.nonshrink_count + 16'd1;
        end else begin
            w_count = 16'd0;
        end
    end

    // limit compares
    assign w_elapsed   = i_item.now_ms - i_item.last_msg_ms;
    assign w_enc_bad   = w_mag > i_cfg.max_encoder_step;
    assign w_range_bad = ($signed(i_item.sample_value) < $signed(i_cfg.position_low))
                      || ($signed(i_item.sample_value) > $signed(i_cfg.position_high));
    assign w_link_bad  = w_elapsed > i_cfg.link_timeout_ms;

    // command decode and state update
    always_comb begin
        w_next    = i_state;
        w_tripped = 1'b0;
        unique case (i_item.cmd)
            CMD_MOVE_RST: begin
                w_next.previous_error_mag = '0;
                w_next.nonshrink_count    = '0;
            end
            CMD_CLEAR: begin
                w_next.fault_flag = 1'b0;
                w_next.fault_kind = CODE_NONE;
            end
            CMD_ENCODER: begin
                if (!i_state.fault_flag && w_enc_bad) begin
                    w_next.fault_flag = 1'b1;
                    w_next.fault_kind = CODE_ENCODER;
                    w_tripped         = 1'b1;
                end
            end
            CMD_RANGE: begin
                if (!i_state.fault_flag && w_range_bad) begin
                    w_next.fault_flag = 1'b1;
                    w_next.fault_kind = CODE_RANGE;
                    w_tripped         = 1'b1;
                end
            end
            CMD_MOVE: begin
                if (!i_state.fault_flag) begin
                    // collision has priority over stall
                    if (w_count >= i_cfg.collision_limit) begin
                        w_next.fault_flag = 1'b1;
                        w_next.fault_kind = CODE_COLLISION;
                        w_tripped         = 1'b1;
                    end else if (w_count >= i_cfg.stall_limit) begin
                        w_next.fault_flag = 1'b1;
                        w_next.fault_kind = CODE_MOVE_FAIL;
                        w_tripped         = 1'b1;
                    end
                    if (w_tripped) begin
                        w_next.previous_error_mag = '0;
                        w_next.nonshrink_count    = '0;
                    end else begin
                        w_next.previous_error_mag = w_mag;
                        w_next.nonshrink_count    = w_count;
                    end
                end
            end
            CMD_LINK: begin
                if (!i_state.fault_flag && w_link_bad) begin
                    w_next.fault_flag = 1'b1;
                    w_next.fault_kind = CODE_LINK;
                    w_tripped         = 1'b1;
                end
            end
            default: begin
                w_next = i_state;
            end
        endcase
    end

    assign o_state                = w_next;
    assign o_result.tripped       = w_tripped;
    assign o_result.fault_latched = w_next.fault_flag;
    assign o_result.fault_code    = w_next.fault_kind;

endmodule

`default_nettype wire

FILE: rtl/joint_fault_monitor.sv
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_ready    i_cmd, i_sample_value, i_last_msg_ms, i_now_ms
// out       source     o_out_valid / i_out_ready  o_tripped, o_fault_latched, o_fault_code
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one request per cycle sustained while the output is not stalled; a request's result reaches the
// outputs through the input register, then the check logic into the result register
// the fault and tracker state update in the same cycle the result register loads
// synchronous active-low reset clears state and loads register defaults
// a stalled output holds its result while the input register still takes one more request
`default_nettype none

module joint_fault_monitor (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic [31:0]        i_last_msg_ms,
    input  wire logic [31:0]        i_now_ms,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_tripped,
    output logic                    o_fault_latched,
    output logic [2:0]              o_fault_code,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import jfm_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_adv;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    jfm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // the held request moves on when the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.cmd          <= i_cmd;
            r_item.sample_value <= i_sample_value;
            r_item.last_msg_ms  <= i_last_msg_ms;
            r_item.now_ms       <= i_now_ms;
        end
    end

    // check logic
    jfm_check u_check (
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // fault and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tripped       = r_result.tripped;
    assign o_fault_latched = r_result.fault_latched;
    assign o_fault_code    = r_result.fault_code;

    // a latched fault always carries a code, and no code without a fault
    a_code_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault_latched == (o_fault_code != CODE_NONE)))
        else $error("fault code disagrees with fault flag");

    // a trip always leaves the fault latched
    a_trip_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tripped |-> o_fault_latched)
        else $error("trip reported without latched fault");

    // only the clear command may change a latched fault code
    a_kind_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_state.fault_flag && (r_item.cmd != CMD_CLEAR)
        |=> r_state.fault_kind == $past(r_state.fault_kind))
        else $error("latched fault code changed");

    // a held request is never dropped while the output stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_item))
        else $error("held request lost");

endmodule

`default_nettype wire
